### hw/rtl/tmcw_pkg.sv
// Package for the text-mode console writer: screen geometry, codes and the
// payload and command structs shared by the front, the queue and the back.
// No dependencies.
package tmcw_pkg;

   // Screen geometry
   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int SCROLL_BASE = COLUMNS * (ROWS - 1);   // first cell of the bottom row

   localparam int ADDR_W = 11;                // fixed by the cell_index field
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Action codes
   localparam logic [1:0] ACTION_PUT   = 2'd0;
   localparam logic [1:0] ACTION_CLEAR = 2'd1;
   localparam logic [1:0] ACTION_READ  = 2'd2;

   // Character and cell codes
   localparam logic [7:0]  CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0]  CHAR_SPACE     = 8'h20;
   localparam logic [7:0]  CHAR_PRINT_LO  = 8'h20;
   localparam logic [7:0]  CHAR_PRINT_HI  = 8'h7E;
   localparam logic [15:0] BLANK_CELL     = 16'h0720;
   localparam logic [7:0]  COLOR_RESET    = 8'h07;

   typedef struct packed {
      logic [1:0]        action;
      logic [7:0]        char_code;
      logic [ADDR_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [15:0]       cell_value;
      logic [ADDR_W-1:0] cursor_position;
      logic              scrolled;
   } rsp_type;

   // Work handed from the front to the back
   typedef struct packed {
      logic              do_write;
      logic              do_scroll;
      logic              do_clear;
      logic              do_read;
      logic              read_valid;       // read address inside the screen
      logic [ADDR_W-1:0] addr;             // write or read address
      logic [15:0]       cell_data;        // cell to write
      logic [7:0]        fill_attr;        // attribute for the row blanked by a scroll
      logic [ADDR_W-1:0] cursor_position;
   } cmd_type;

endpackage

### hw/rtl/tmcw_front.sv
// Front end of the console writer: takes request beats, keeps the cursor and
// the colour register, and turns each beat into a command. Uses tmcw_pkg.
module tmcw_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tmcw_pkg::req_type req_data,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data,
   input  logic             back_ready,
   input  logic             queue_full,
   output logic             push,
   output tmcw_pkg::cmd_type push_cmd
);

   logic [tmcw_pkg::ROW_W-1:0] row_ff, row_in;
   logic [tmcw_pkg::COL_W-1:0] col_ff, col_in;
   logic [7:0]                 color_ff;
   logic [tmcw_pkg::COL_W:0]   col_wide;
   logic [tmcw_pkg::ADDR_W-1:0] pos;
   logic                       next_row;

   assign req_ready = back_ready && !queue_full;
   assign push      = req_valid && req_ready;

   assign pos = tmcw_pkg::ADDR_W'(row_ff) * tmcw_pkg::ADDR_W'(tmcw_pkg::COLUMNS)
              + tmcw_pkg::ADDR_W'(col_ff);
   assign col_wide = {1'b0, col_ff} + 1'b1;

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      next_row = 1'b0;
      push_cmd = '0;
      push_cmd.fill_attr = color_ff;
      case (req_data.action)
         tmcw_pkg::ACTION_PUT: begin
            if (req_data.char_code == tmcw_pkg::CHAR_NEWLINE) begin
               col_in   = '0;
               next_row = 1'b1;
            end else if (req_data.char_code inside
                         {[tmcw_pkg::CHAR_PRINT_LO:tmcw_pkg::CHAR_PRINT_HI]}) begin
               push_cmd.do_write  = 1'b1;
               push_cmd.addr      = pos;
               push_cmd.cell_data = {color_ff, req_data.char_code};
               if (col_wide >= (tmcw_pkg::COL_W + 1)'(tmcw_pkg::COLUMNS)) begin
                  col_in   = '0;
                  next_row = 1'b1;
               end else begin
                  col_in = col_wide[tmcw_pkg::COL_W-1:0];
               end
            end
            if (next_row) begin
               if (row_ff == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1)) begin
                  push_cmd.do_scroll = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         tmcw_pkg::ACTION_CLEAR: begin
            row_in            = '0;
            col_in            = '0;
            push_cmd.do_clear = 1'b1;
         end
         tmcw_pkg::ACTION_READ: begin
            push_cmd.do_read    = 1'b1;
            push_cmd.addr       = req_data.cell_index;
            push_cmd.read_valid =
               (req_data.cell_index < tmcw_pkg::ADDR_W'(tmcw_pkg::CELL_COUNT));
         end
         default: begin
         end
      endcase
      push_cmd.cursor_position =
         tmcw_pkg::ADDR_W'(row_in) * tmcw_pkg::ADDR_W'(tmcw_pkg::COLUMNS)
         + tmcw_pkg::ADDR_W'(col_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         color_ff <= tmcw_pkg::COLOR_RESET;
      end else begin
         if (push) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (csr_write_enable) begin
            color_ff <= csr_write_data;
         end
      end
   end

endmodule

### hw/rtl/tmcw_cmd_queue.sv
// Short command queue between the console front and back.
// Uses tmcw_pkg.
module tmcw_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tmcw_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output tmcw_pkg::cmd_type head
);

   tmcw_pkg::cmd_type           entry_ff [tmcw_pkg::QUEUE_DEPTH];
   logic [tmcw_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tmcw_pkg::QCNT_W-1:0] count_ff;

   assign full  = (count_ff == tmcw_pkg::QCNT_W'(tmcw_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == tmcw_pkg::QPTR_W'(tmcw_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == tmcw_pkg::QPTR_W'(tmcw_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### hw/rtl/tmcw_back.sv
// Back end of the console writer: owns the screen memory, carries out
// writes, reads, scrolls and clears, and holds the response register.
// Uses tmcw_pkg.
module tmcw_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  tmcw_pkg::cmd_type head,
   output logic             pop,
   output logic             back_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tmcw_pkg::rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_COPY  = 6'b001000,
      ST_FILL  = 6'b010000,
      ST_CLEAR = 6'b100000
   } state_type;

   localparam int AW = tmcw_pkg::ADDR_W;

   state_type         state_ff, state_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic              pend_ff;
   logic [AW-1:0]     pend_addr_ff;
   tmcw_pkg::cmd_type cur_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   tmcw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [15:0]       mem [tmcw_pkg::CELL_COUNT];
   logic [15:0]       rd_data_ff;
   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [15:0]       wr_data;
   logic              slot_free;
   logic              sweep_last;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign pop        = (state_ff == ST_IDLE) && !queue_empty && slot_free;
   assign back_ready = (state_ff != ST_INIT);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign sweep_last = (sweep_ff == AW'(tmcw_pkg::CELL_COUNT - 1));

   // Memory port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head.addr;
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = tmcw_pkg::BLANK_CELL;
      if (state_ff == ST_COPY) begin
         rd_en   = 1'b1;
         rd_addr = sweep_ff + AW'(tmcw_pkg::COLUMNS);
      end else if (state_ff == ST_IDLE) begin
         rd_en = pop && head.do_read;
      end
      if (pend_ff) begin
         // copy write lands in the cycle after its read
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rd_data_ff;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               wr_en   = pop && head.do_write;
               wr_addr = head.addr;
               wr_data = head.cell_data;
            end
            ST_FILL: begin
               wr_en   = 1'b1;
               wr_data = {cur_ff.fill_attr, tmcw_pkg::CHAR_SPACE};
            end
            ST_INIT, ST_CLEAR: begin
               wr_en = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = ST_IDLE;
               sweep_in = '0;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               sweep_in = '0;
               if (head.do_clear) begin
                  state_in = ST_CLEAR;
               end else if (head.do_read) begin
                  state_in = ST_READ;
               end else if (head.do_scroll) begin
                  state_in = ST_COPY;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{cell_value: '0,
                                   cursor_position: head.cursor_position,
                                   scrolled: 1'b0};
               end
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{cell_value: cur_ff.read_valid ? rd_data_ff : 16'h0000,
                             cursor_position: cur_ff.cursor_position,
                             scrolled: 1'b0};
         end
         ST_COPY: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == AW'(tmcw_pkg::SCROLL_BASE - 1)) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (!pend_ff) begin
               sweep_in = sweep_ff + 1'b1;
               if (sweep_last) begin
                  state_in     = ST_IDLE;
                  sweep_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{cell_value: '0,
                                   cursor_position: cur_ff.cursor_position,
                                   scrolled: 1'b1};
               end
            end
         end
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in     = ST_IDLE;
               sweep_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{cell_value: '0,
                                cursor_position: cur_ff.cursor_position,
                                scrolled: 1'b0};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= (state_ff == ST_COPY);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= sweep_ff;
      rsp_data_ff  <= rsp_data_in;
      if (pop) begin
         cur_ff <= head;
      end
   end

endmodule

### hw/rtl/text_mode_console_writer_core.sv
// Top level of the text-mode console writer: front end, command queue and
// back end with the screen memory. Uses tmcw_pkg, tmcw_front,
// tmcw_cmd_queue and tmcw_back.
//
//   channel   ports                                   beat taken when
//   request   req_valid, req_ready, req_data          req_valid && req_ready
//   response  rsp_valid, rsp_ready, rsp_data          rsp_valid && rsp_ready
//   colour    csr_write_enable, csr_write_data        csr_write_enable
//
// Cycles: the front takes one request beat a cycle while the queue has room.
// The back, with its single write port on the screen memory, sets the pace:
// a put or no-op is done as it is taken, a read goes through ST_READ, a clear
// blanks every cell, and a put that scrolls copies rows one cell a cycle.
// Reset: a clearing pass over COLUMNS*ROWS (2000) cells blanks the screen;
// req_ready stays low until it ends. Colour writes are taken throughout.
// Stalls: the two-deep queue lets the front keep accepting while the back
// is busy; the response register holds a finished response until rsp_ready,
// and the back takes no new command while it is full and not being drained.
module text_mode_console_writer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tmcw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tmcw_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);

   logic              push, pop;
   logic              queue_full, queue_empty;
   logic              back_ready;
   tmcw_pkg::cmd_type push_cmd, head;

   // Front: classifies each beat and moves the cursor
   tmcw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .back_ready       (back_ready),
      .queue_full       (queue_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   tmcw_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   // Back: screen memory, scroll and clear sweeps, response register
   tmcw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .back_ready  (back_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for text_mode_console_writer_core: directed, wrap/scroll,
// backpressure and random tests against an in-bench model of the console.
// Depends on tmcw_pkg and the RTL of the core only.
`timescale 1ns / 100ps

module tb_top;

   // Action code the block must ignore
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   // Timing bounds for the watchdog: worst beat is a put that scrolls, each beat
   // may also meet a full idle burst on both sides.
   localparam int unsigned MAX_BURST     = 17;
   localparam int unsigned SLOWEST_BEAT  = tmcw_pkg::CELL_COUNT + 2;
   localparam int unsigned BEAT_BOUND    = 2000;
   localparam int unsigned HOLD_OFF      = 400;
   localparam int unsigned END_WAIT      = tmcw_pkg::CELL_COUNT + 100;
   localparam int unsigned CYCLE_LIMIT   =
      3 * (BEAT_BOUND * (SLOWEST_BEAT + 2 * MAX_BURST) + tmcw_pkg::CELL_COUNT
           + END_WAIT + HOLD_OFF);
   localparam int unsigned RANDOM_PER_PHASE = 160;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   tmcw_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   tmcw_pkg::rsp_type rsp_data;
   logic    csr_write_enable;
   logic [7:0] csr_write_data;

   // Model of the console: screen, cursor and colour register
   logic [15:0] screen_model [tmcw_pkg::CELL_COUNT];
   int          cur_row;
   int          cur_col;
   logic [7:0]  text_colour;

   tmcw_pkg::rsp_type expected_console_q [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count;
   bit          idling_on = 1'b0;
   int unsigned rsp_hold_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   text_mode_console_writer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------------
   // Console model
   // ---------------------------------------------------------------------------

   // Clear and reset both leave every cell grey-on-black space, colour aside.
   function automatic void blank_screen_model();
      int i;
      for (i = 0; i < tmcw_pkg::CELL_COUNT; i++) screen_model[i] = tmcw_pkg::BLANK_CELL;
   endfunction

   // Works out the response beat for one request and moves the model on.
   function automatic tmcw_pkg::rsp_type console_step(input tmcw_pkg::req_type beat);
      tmcw_pkg::rsp_type outcome;
      bit      next_row;
      int      i;
      int      pos_now;
      outcome  = '0;
      next_row = 1'b0;
      case (beat.action)
         tmcw_pkg::ACTION_PUT: begin
            if (beat.char_code == tmcw_pkg::CHAR_NEWLINE) begin
               cur_col  = 0;
               next_row = 1'b1;
            end else if (beat.char_code >= tmcw_pkg::CHAR_PRINT_LO &&
                         beat.char_code <= tmcw_pkg::CHAR_PRINT_HI) begin
               screen_model[cur_row * tmcw_pkg::COLUMNS + cur_col] =
                  {text_colour, beat.char_code};
               cur_col++;
               // full row wraps to the start of the next one
               if (cur_col >= tmcw_pkg::COLUMNS) begin
                  cur_col  = 0;
                  next_row = 1'b1;
               end
            end
            // anything else is ignored: no write, cursor stays put
            if (next_row) begin
               cur_row++;
               if (cur_row >= tmcw_pkg::ROWS) begin
                  // past the bottom: shift up one row, blank the bottom in the
                  // current colour
                  for (i = 0; i < tmcw_pkg::SCROLL_BASE; i++)
                     screen_model[i] = screen_model[i + tmcw_pkg::COLUMNS];
                  for (i = tmcw_pkg::SCROLL_BASE; i < tmcw_pkg::CELL_COUNT; i++)
                     screen_model[i] = {text_colour, tmcw_pkg::CHAR_SPACE};
                  cur_row = tmcw_pkg::ROWS - 1;
                  outcome.scrolled = 1'b1;
               end
            end
         end
         tmcw_pkg::ACTION_CLEAR: begin
            blank_screen_model();
            cur_row = 0;
            cur_col = 0;
         end
         tmcw_pkg::ACTION_READ: begin
            // out-of-range addresses read back as zero
            if (beat.cell_index < tmcw_pkg::CELL_COUNT)
               outcome.cell_value = screen_model[beat.cell_index];
         end
         default: ;
      endcase
      pos_now = cur_row * tmcw_pkg::COLUMNS + cur_col;
      outcome.cursor_position = pos_now[tmcw_pkg::ADDR_W-1:0];
      return outcome;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   function automatic tmcw_pkg::req_type make_beat(input logic [1:0] action,
                                                   input logic [7:0] char_code,
                                                   input logic [tmcw_pkg::ADDR_W-1:0] cell_index);
      tmcw_pkg::req_type beat;
      beat.action     = action;
      beat.char_code  = char_code;
      beat.cell_index = cell_index;
      return beat;
   endfunction

   // Offers one request beat, optionally after an idle burst, and records the
   // expected response once the beat is taken.
   task automatic send_console_beat(input tmcw_pkg::req_type beat);
      int unsigned span;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         span = $urandom_range(1, MAX_BURST);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (span - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = beat;
      do @(posedge clock); while (!req_ready);
      expected_console_q.push_back(console_step(beat));
   endtask

   // Drops valid and waits for every outstanding response; every request gives
   // exactly one, so an empty queue means the core is idle.
   task automatic settle_console();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_console_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_text_colour(input logic [7:0] colour);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = colour;
      @(negedge clock);
      csr_write_enable = 1'b0;
      text_colour      = colour;
   endtask

   function automatic logic [7:0] random_printable();
      return 8'($urandom_range(tmcw_pkg::CHAR_PRINT_LO, tmcw_pkg::CHAR_PRINT_HI));
   endfunction

   // Mostly printing and reading, with some noise: unprintable bytes, the unused
   // action, out-of-range reads. ignored flags beats that change nothing.
   function automatic tmcw_pkg::req_type random_console_beat(output bit ignored);
      tmcw_pkg::req_type beat;
      int unsigned pick;
      int          here;
      int          back;
      logic [7:0]  noise;
      beat       = tmcw_pkg::req_type'($urandom);
      ignored    = 1'b0;
      pick       = $urandom_range(0, 99);
      if (pick < 60 || pick >= 98) begin
         beat.action    = tmcw_pkg::ACTION_PUT;
         beat.char_code = random_printable();
      end else if (pick < 67) begin
         beat.action    = tmcw_pkg::ACTION_PUT;
         beat.char_code = tmcw_pkg::CHAR_NEWLINE;
      end else if (pick < 72) begin
         case ($urandom_range(0, 2))
            0: begin
               do noise = 8'($urandom_range(0, tmcw_pkg::CHAR_PRINT_LO - 1));
               while (noise == tmcw_pkg::CHAR_NEWLINE);
            end
            1:       noise = tmcw_pkg::CHAR_PRINT_HI + 8'd1;
            default: noise = 8'($urandom_range(tmcw_pkg::CHAR_PRINT_HI + 1, 8'hFF));
         endcase
         beat.action    = tmcw_pkg::ACTION_PUT;
         beat.char_code = noise;
         ignored        = 1'b1;
      end else if (pick < 92) begin
         beat.action = tmcw_pkg::ACTION_READ;
         if ($urandom_range(0, 1) == 0) begin
            // just behind the cursor, where the fresh text is
            here = cur_row * tmcw_pkg::COLUMNS + cur_col;
            back = $urandom_range(0, 2 * tmcw_pkg::COLUMNS);
            beat.cell_index = (here > back) ? tmcw_pkg::ADDR_W'(here - back) : '0;
         end else begin
            beat.cell_index =
               tmcw_pkg::ADDR_W'($urandom_range(0, tmcw_pkg::CELL_COUNT - 1));
         end
      end else if (pick < 95) begin
         beat.action     = tmcw_pkg::ACTION_READ;
         beat.cell_index = tmcw_pkg::ADDR_W'($urandom_range(tmcw_pkg::CELL_COUNT,
                                                            2 ** tmcw_pkg::ADDR_W - 1));
      end else if (pick < 97) begin
         beat.action = ACTION_UNUSED;
         ignored     = 1'b1;
      end else begin
         beat.action = tmcw_pkg::ACTION_CLEAR;
      end
      return beat;
   endfunction

   // ---------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------

   // rsp_ready: random stall bursts while idling is on, and a long hold-off on
   // request, counted here.
   initial begin : rsp_ready_driver
      int unsigned span;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            span            = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready       = 1'b0;
            repeat (span - 1) @(negedge clock);
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            span      = $urandom_range(1, MAX_BURST);
            rsp_ready = 1'b0;
            repeat (span - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Each accepted response beat against the oldest expectation.
   always @(posedge clock) begin : response_check
      tmcw_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_console_q.size() == 0) begin
            $error("response beat with nothing outstanding: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = expected_console_q.pop_front();
            if (rsp_data.cell_value !== want.cell_value) begin
               $error("cell_value: expected %h, got %h", want.cell_value, rsp_data.cell_value);
               mismatch_count++;
            end
            if (rsp_data.cursor_position !== want.cursor_position) begin
               $error("cursor_position: expected %0d, got %0d",
                      want.cursor_position, rsp_data.cursor_position);
               mismatch_count++;
            end
            if (rsp_data.scrolled !== want.scrolled) begin
               $error("scrolled: expected %b, got %b", want.scrolled, rsp_data.scrolled);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes and each special case, at the reset colour.
   task automatic test_directed();
      int i;
      idling_on = 1'b1;
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'd0));     // blank after reset
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'hFF, 11'd1999));  // last cell
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'd2000));  // first off screen
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'h7FF));   // top of the field
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, 8'h41, 11'h7FF));    // 'A'
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, tmcw_pkg::CHAR_PRINT_LO, '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, tmcw_pkg::CHAR_PRINT_HI, '0));
      // below printable, then DEL
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, tmcw_pkg::CHAR_PRINT_LO - 8'd1, '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, tmcw_pkg::CHAR_PRINT_HI + 8'd1, '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, 8'h00, '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, 8'hFF, '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, tmcw_pkg::CHAR_NEWLINE, '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, 8'h7A, '0));         // 'z' at row 1
      for (i = 0; i < 4; i++)
         send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, i[tmcw_pkg::ADDR_W-1:0]));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'd80));
      // unused action: no effect even when it carries a newline
      send_console_beat(make_beat(ACTION_UNUSED, 8'hFF, 11'h7FF));
      send_console_beat(make_beat(ACTION_UNUSED, tmcw_pkg::CHAR_NEWLINE, '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_CLEAR, 8'h41, 11'd5));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'd0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'd80));
      settle_console();
   endtask

   // Full rows wrap; the bottom row scrolls both by wrapping and by newline.
   task automatic test_wrap_and_scroll();
      int i;
      write_text_colour(8'hFF);
      send_console_beat(make_beat(tmcw_pkg::ACTION_CLEAR, 8'h00, '0));
      for (i = 0; i < tmcw_pkg::COLUMNS; i++)
         send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, random_printable(),
                                     tmcw_pkg::ADDR_W'($urandom)));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'd0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'd79));
      for (i = 0; i < tmcw_pkg::ROWS - 2; i++)
         send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, tmcw_pkg::CHAR_NEWLINE, '0));
      // bottom row: the last character wraps and scrolls
      for (i = 0; i < tmcw_pkg::COLUMNS; i++)
         send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, random_printable(), '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, tmcw_pkg::CHAR_NEWLINE, '0));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'(tmcw_pkg::SCROLL_BASE)));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00,
                                  11'(tmcw_pkg::CELL_COUNT - 1)));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00,
                                  11'(tmcw_pkg::SCROLL_BASE - 2 * tmcw_pkg::COLUMNS)));
      send_console_beat(make_beat(tmcw_pkg::ACTION_READ, 8'h00, 11'd0));
      settle_console();
   endtask

   // Receiver holds off for a long stretch while beats keep coming: the queue
   // fills and req_ready must drop without losing anything.
   task automatic test_backpressure();
      int i;
      idling_on = 1'b0;
      write_text_colour(8'($urandom));
      rsp_hold_cycles = HOLD_OFF;
      for (i = 0; i < 40; i++)
         send_console_beat(make_beat(tmcw_pkg::ACTION_PUT, random_printable(), '0));
      settle_console();
   endtask

   // Random traffic over several colours; one middle phase and the last phase
   // run without idling.
   task automatic test_random_mix();
      logic [7:0]  colours [5];
      int          phase;
      int unsigned counted;
      bit          ignored;
      tmcw_pkg::req_type beat;
      colours[0] = 8'h00;
      colours[1] = 8'($urandom);
      colours[2] = 8'h1E;
      colours[3] = 8'($urandom);
      colours[4] = 8'hF0;
      for (phase = 0; phase < 5; phase++) begin
         settle_console();
         write_text_colour(colours[phase]);
         idling_on = (phase != 2) && (phase != 4);
         counted   = 0;
         while (counted < RANDOM_PER_PHASE) begin
            beat = random_console_beat(ignored);
            send_console_beat(beat);
            if (!ignored) counted++;
         end
      end
      settle_console();
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin : run_sequence
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      blank_screen_model();
      cur_row     = 0;
      cur_col     = 0;
      text_colour = tmcw_pkg::COLOR_RESET;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // req_ready stays low through the clearing pass; the first send waits
      test_directed();
      test_wrap_and_scroll();
      test_backpressure();
      test_random_mix();

      // catch any stray response after the last one expected
      repeat (END_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a missing response ends up here.
   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_front.sv
hw/rtl/tmcw_cmd_queue.sv
hw/rtl/tmcw_back.sv
hw/rtl/text_mode_console_writer_core.sv
tb/sv/tb_top.sv
